>>> rtl/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types and widths for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	localparam int unsigned COMP_W = 32;  // Q16.16 component
	localparam int unsigned PROD_W = 64;  // one Q32.32 product
	localparam int unsigned SUM_W  = 67;  // exact sum of four products
	localparam int unsigned MAG_W  = 66;  // magnitude of a sum
	localparam int unsigned DEN_W  = 65;  // |b|^2 is at most 2^64
	localparam int unsigned REM_W  = 98;  // divisor shifted by up to 31 bits
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned NPROD  = 4;

endpackage

>>> rtl/quaternion_arith_unit.sv
// ----------------------------------------------------------------------------
// quaternion_arith_unit
// Quaternion add, subtract, Hamilton product and quotient on Q16.16 operands.
//
//   channel   handshake          payload
//   command   start / busy       operation, a_r..a_k, b_r..b_k
//   result    done (strobe)      res_r..res_k, divide_by_zero, overflow
//
// One transaction is taken every cycle; busy is always low.
// Every operation passes through two multiplier/adder stages, an entry
// stage, 32 divider stages (one quotient bit each) and an output
// register. Results leave in order, one cycle each, and cannot be stalled.
// Reset clears only the valid pipeline.
// ----------------------------------------------------------------------------
module quaternion_arith_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        operation,
	input  logic signed [qau_pkg::COMP_W-1:0] a_r,
	input  logic signed [qau_pkg::COMP_W-1:0] a_i,
	input  logic signed [qau_pkg::COMP_W-1:0] a_j,
	input  logic signed [qau_pkg::COMP_W-1:0] a_k,
	input  logic signed [qau_pkg::COMP_W-1:0] b_r,
	input  logic signed [qau_pkg::COMP_W-1:0] b_i,
	input  logic signed [qau_pkg::COMP_W-1:0] b_j,
	input  logic signed [qau_pkg::COMP_W-1:0] b_k,
	output logic                              done,
	output logic signed [qau_pkg::COMP_W-1:0] res_r,
	output logic signed [qau_pkg::COMP_W-1:0] res_i,
	output logic signed [qau_pkg::COMP_W-1:0] res_j,
	output logic signed [qau_pkg::COMP_W-1:0] res_k,
	output logic                              divide_by_zero,
	output logic                              overflow
);
	import qau_pkg::*;

	localparam int unsigned NL = 4;

	op_t op_c;
	logic signed [COMP_W-1:0] x_c [NL][NPROD];
	logic signed [COMP_W-1:0] y_c [NL][NPROD];
	logic        [NPROD-1:0]  n_c [NL];
	logic signed [COMP_W-1:0] dx_c [NPROD];
	logic signed [SUM_W-1:0]  sum_s2 [NL];
	logic signed [SUM_W-1:0]  den_s2;
	logic                     vld_s1, vld_s2;
	op_t                      op_s1, op_s2;
	logic                     ovld [NL];
	logic [COMP_W-1:0]        ores [NL];
	logic                     oovf [NL];
	logic                     odz  [NL];
	logic signed [COMP_W-1:0] av [NL];
	logic signed [COMP_W-1:0] bv [NL];

	assign busy = 1'b0;
	assign op_c = op_t'(operation);
	assign av = '{a_r, a_i, a_j, a_k};
	assign bv = '{b_r, b_i, b_j, b_k};
	assign dx_c = '{b_r, b_i, b_j, b_k};

	// Route operands and term signs to each lane
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			for (int k = 0; k < NPROD; k++) begin
				x_c[l][k] = '0;
				y_c[l][k] = '0;
			end
			n_c[l] = '0;
		end
		unique case (op_c)
			OP_ADD, OP_SUB: begin
				for (int l = 0; l < NL; l++) begin
					x_c[l][0] = av[l];
					y_c[l][0] = COMP_W'(1);
					x_c[l][1] = bv[l];
					y_c[l][1] = COMP_W'(1);
					n_c[l][1] = (op_c == OP_SUB);
				end
			end
			OP_MUL: begin
				x_c[0] = '{a_r, a_i, a_j, a_k}; y_c[0] = '{b_r, b_i, b_j, b_k};
				n_c[0] = 4'b1110;
				x_c[1] = '{a_r, a_i, a_j, a_k}; y_c[1] = '{b_i, b_r, b_k, b_j};
				n_c[1] = 4'b1000;
				x_c[2] = '{a_r, a_i, a_j, a_k}; y_c[2] = '{b_j, b_k, b_r, b_i};
				n_c[2] = 4'b0010;
				x_c[3] = '{a_r, a_i, a_j, a_k}; y_c[3] = '{b_k, b_j, b_i, b_r};
				n_c[3] = 4'b0100;
			end
			OP_DIV: begin
				x_c[0] = '{a_r, a_i, a_j, a_k}; y_c[0] = '{b_r, b_i, b_j, b_k};
				n_c[0] = 4'b0000;
				x_c[1] = '{a_i, a_j, a_k, a_r}; y_c[1] = '{b_r, b_k, b_j, b_i};
				n_c[1] = 4'b1010;
				x_c[2] = '{a_i, a_j, a_k, a_r}; y_c[2] = '{b_k, b_r, b_i, b_j};
				n_c[2] = 4'b1100;
				x_c[3] = '{a_j, a_k, a_r, a_i}; y_c[3] = '{b_i, b_r, b_k, b_j};
				n_c[3] = 4'b1100;
			end
			default: begin
			end
		endcase
	end

	// Component lanes
	for (genvar l = 0; l < NL; l++) begin : g_lane
		qau_lane u_lane (
			.clk    (clk),
			.x      (x_c[l]),
			.y      (y_c[l]),
			.neg    (n_c[l]),
			.sum_s2 (sum_s2[l])
		);
	end

	// Divisor norm lane
	qau_lane u_norm (
		.clk    (clk),
		.x      (dx_c),
		.y      (dx_c),
		.neg    ('0),
		.sum_s2 (den_s2)
	);

	// Track transactions through the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= op_c;
		op_s2 <= op_s1;
	end

	// Divide and saturate each component
	for (genvar l = 0; l < NL; l++) begin : g_div
		qau_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_s2),
			.op        (op_s2),
			.num       (sum_s2[l]),
			.den       (den_s2),
			.out_valid (ovld[l]),
			.res       (ores[l]),
			.ovf       (oovf[l]),
			.dz        (odz[l])
		);
	end

	// Merge the lane results
	assign done           = ovld[0] & ovld[1] & ovld[2] & ovld[3];
	assign res_r          = ores[0];
	assign res_i          = ores[1];
	assign res_j          = ores[2];
	assign res_k          = ores[3];
	assign divide_by_zero = odz[0] & odz[1] & odz[2] & odz[3];
	assign overflow       = oovf[0] | oovf[1] | oovf[2] | oovf[3];

	// A zero divisor yields a clean zero result
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_by_zero |-> !overflow && res_r == '0 && res_i == '0 &&
		res_j == '0 && res_k == '0)
		else $error("divide by zero result not clean");

	// Overflow means some component sits at a rail
	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflow |->
		res_r == 32'h7fffffff || res_r == 32'h80000000 ||
		res_i == 32'h7fffffff || res_i == 32'h80000000 ||
		res_j == 32'h7fffffff || res_j == 32'h80000000 ||
		res_k == 32'h7fffffff || res_k == 32'h80000000)
		else $error("overflow without saturated component");

	// Lanes stay in lockstep
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		ovld[0] == ovld[1] && ovld[0] == ovld[2] && ovld[0] == ovld[3])
		else $error("lane valid mismatch");

endmodule

>>> rtl/qau_lane.sv
// ----------------------------------------------------------------------------
// qau_lane
// One result component: four signed 32x32 products, registered, then a
// signed sum of four with a per-term sign, registered.
// ----------------------------------------------------------------------------
module qau_lane (
	input  logic                                  clk,
	input  logic signed [qau_pkg::COMP_W-1:0]     x [qau_pkg::NPROD],
	input  logic signed [qau_pkg::COMP_W-1:0]     y [qau_pkg::NPROD],
	input  logic        [qau_pkg::NPROD-1:0]      neg,
	output logic signed [qau_pkg::SUM_W-1:0]      sum_s2
);
	import qau_pkg::*;

	logic signed [PROD_W-1:0] prod_s1 [NPROD];
	logic        [NPROD-1:0]  neg_s1;
	logic signed [SUM_W-1:0]  sum_c;

	// Form the products
	always_ff @(posedge clk) begin
		for (int k = 0; k < NPROD; k++) begin
			prod_s1[k] <= PROD_W'(x[k]) * PROD_W'(y[k]);
		end
		neg_s1 <= neg;
	end

	// Add the signed terms
	always_comb begin
		sum_c = '0;
		for (int k = 0; k < NPROD; k++) begin
			if (neg_s1[k]) begin
				sum_c = sum_c - SUM_W'(prod_s1[k]);
			end else begin
				sum_c = sum_c + SUM_W'(prod_s1[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum_c;
	end

endmodule

>>> rtl/qau_div.sv
// ----------------------------------------------------------------------------
// qau_div
// Final stage of one component: saturation for add, subtract and multiply,
// and a pipelined restoring divider (one quotient bit per stage) for divide.
// ----------------------------------------------------------------------------
module qau_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  qau_pkg::op_t                          op,
	input  logic signed [qau_pkg::SUM_W-1:0]      num,
	input  logic signed [qau_pkg::SUM_W-1:0]      den,
	output logic                                  out_valid,
	output logic        [qau_pkg::COMP_W-1:0]     res,
	output logic                                  ovf,
	output logic                                  dz
);
	import qau_pkg::*;

	localparam int unsigned NST = COMP_W + 1;
	localparam logic [COMP_W-1:0] POS_MAX = {1'b0, {(COMP_W-1){1'b1}}};
	localparam logic [COMP_W-1:0] NEG_MIN = {1'b1, {(COMP_W-1){1'b0}}};

	// entry logic
	logic                    neg_c;
	logic [SUM_W-1:0]        abs_c;
	logic [MAG_W-1:0]        mag_c;
	logic [DEN_W-1:0]        den_c;
	logic                    big_c;
	logic signed [SUM_W-1:0] shv_c;
	logic [COMP_W-1:0]       fix_c;
	logic                    fovf_c;

	// divider stages
	logic                    vld_q  [NST];
	logic [REM_W-1:0]        rem_q  [NST];
	logic [COMP_W-1:0]       quo_q  [NST];
	logic [DEN_W-1:0]        den_q  [NST];
	logic                    neg_q  [NST];
	logic                    big_q  [NST];
	logic                    dz_q   [NST];
	logic                    isd_q  [NST];
	logic [COMP_W-1:0]       fix_q  [NST];
	logic                    fovf_q [NST];

	// Prepare magnitude, overflow precheck and the non-divide result
	always_comb begin
		neg_c = num[SUM_W-1];
		abs_c = neg_c ? SUM_W'(-num) : SUM_W'(num);
		mag_c = abs_c[MAG_W-1:0];
		den_c = den[DEN_W-1:0];
		big_c = ({16'b0, mag_c} >= {den_c, 17'b0} >> 1);
		shv_c = (op == OP_MUL) ? (num >>> FRAC_W) : num;
		if (shv_c > SUM_W'(signed'({1'b0, POS_MAX}))) begin
			fix_c  = POS_MAX;
			fovf_c = 1'b1;
		end else if (shv_c < -SUM_W'(signed'({1'b0, NEG_MIN}))) begin
			fix_c  = NEG_MIN;
			fovf_c = 1'b1;
		end else begin
			fix_c  = shv_c[COMP_W-1:0];
			fovf_c = 1'b0;
		end
	end

	// Capture the entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else begin
			vld_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0]  <= REM_W'({mag_c, {FRAC_W{1'b0}}});
		quo_q[0]  <= '0;
		den_q[0]  <= den_c;
		neg_q[0]  <= neg_c;
		big_q[0]  <= big_c;
		dz_q[0]   <= (den == '0);
		isd_q[0]  <= (op == OP_DIV);
		fix_q[0]  <= fix_c;
		fovf_q[0] <= fovf_c;
	end

	// Advance one quotient bit per stage, most significant first
	for (genvar st = 0; st < NST - 1; st++) begin : g_stage
		localparam int unsigned B = COMP_W - 1 - st;
		logic [REM_W-1:0] dsh;
		logic             ge;

		assign dsh = REM_W'(den_q[st]) << B;
		assign ge  = (rem_q[st] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[st+1] <= 1'b0;
			end else begin
				vld_q[st+1] <= vld_q[st];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[st+1]  <= ge ? (rem_q[st] - dsh) : rem_q[st];
			quo_q[st+1]  <= quo_q[st] | (ge ? (COMP_W'(1) << B) : '0);
			den_q[st+1]  <= den_q[st];
			neg_q[st+1]  <= neg_q[st];
			big_q[st+1]  <= big_q[st];
			dz_q[st+1]   <= dz_q[st];
			isd_q[st+1]  <= isd_q[st];
			fix_q[st+1]  <= fix_q[st];
			fovf_q[st+1] <= fovf_q[st];
		end
	end

	// Select and saturate the final result
	logic [COMP_W-1:0] res_c;
	logic              ovf_c;
	logic              dz_c;
	logic [COMP_W-1:0] quo_l;

	always_comb begin
		quo_l = quo_q[NST-1];
		res_c = '0;
		ovf_c = 1'b0;
		dz_c  = 1'b0;
		if (!isd_q[NST-1]) begin
			res_c = fix_q[NST-1];
			ovf_c = fovf_q[NST-1];
		end else if (dz_q[NST-1]) begin
			dz_c = 1'b1;
		end else if (neg_q[NST-1]) begin
			if (big_q[NST-1] || quo_l > NEG_MIN) begin
				res_c = NEG_MIN;
				ovf_c = 1'b1;
			end else begin
				res_c = -quo_l;
			end
		end else begin
			if (big_q[NST-1] || quo_l > POS_MAX) begin
				res_c = POS_MAX;
				ovf_c = 1'b1;
			end else begin
				res_c = quo_l;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_q[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		res <= res_c;
		ovf <= ovf_c;
		dz  <= dz_c;
	end

endmodule
